FILE: rtl/utfv_pkg.sv
// utfv_pkg: types, status codes and constants shared by the UTF-8 stream validator.
// No dependencies; every other file in rtl/ takes names from here by scope.
package utfv_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    typedef enum logic {
        CMD_FEED   = 1'b0,
        CMD_FINISH = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_LEAD   = 3'd1,
        ST_BAD_CONT   = 3'd2,
        ST_OVERLONG   = 3'd3,
        ST_SURROGATE  = 3'd4,
        ST_TOO_LARGE  = 3'd5,
        ST_INCOMPLETE = 3'd6,
        ST_POISONED   = 3'd7
    } t_status;

    typedef struct packed {
        logic       command;
        logic [7:0] byte_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        t_status    status;
        logic       last;
    } t_out_item;

    // One classified item: either a release of 1..4 bytes or a single status result.
    typedef struct packed {
        logic [3:0][7:0] seq;
        logic [1:0]      last_idx;
        logic            rel;
        t_status         status;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_push;

    localparam logic [20:0] MIN_CP_2   = 21'h00080;
    localparam logic [20:0] MIN_CP_3   = 21'h00800;
    localparam logic [20:0] MIN_CP_4   = 21'h10000;
    localparam logic [20:0] SURR_LO    = 21'h0D800;
    localparam logic [20:0] SURR_HI    = 21'h0DFFF;
    localparam logic [20:0] MAX_CP     = 21'h10FFFF;

endpackage

FILE: rtl/utfv_front.sv
// utfv_front: accepts items, keeps the pending sequence and poison flag, classifies
// each item into one job. Depends on utfv_pkg.
module utfv_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  utfv_pkg::t_in_item  i_item,
    output utfv_pkg::t_job_push o_push
);

    logic [7:0] r_held [3];
    logic [1:0] r_count;
    logic       r_poison;

    logic [1:0] n_count;
    logic       n_poison;
    logic       held_wr;

    logic [7:0]  b;
    logic [2:0]  len_b;
    logic [2:0]  len_h;
    logic [20:0] cp;
    logic [20:0] min_cp;
    utfv_pkg::t_job job;

    function automatic logic [2:0] lead_len(input logic [7:0] v);
        logic [2:0] l;
        begin
            if (v[7] == 1'b0)              l = 3'd1;
            else if (v[7:5] == 3'b110)     l = 3'd2;
            else if (v[7:4] == 4'b1110)    l = 3'd3;
            else if (v[7:3] == 5'b11110)   l = 3'd4;
            else                           l = 3'd0;
            return l;
        end
    endfunction

    assign b     = i_item.byte_value;
    assign len_b = lead_len(b);
    assign len_h = lead_len(r_held[0]);

    always_comb begin
        case (len_h)
            3'd2: begin
                cp     = {10'd0, r_held[0][4:0], b[5:0]};
                min_cp = utfv_pkg::MIN_CP_2;
            end
            3'd3: begin
                cp     = {5'd0, r_held[0][3:0], r_held[1][5:0], b[5:0]};
                min_cp = utfv_pkg::MIN_CP_3;
            end
            default: begin
                cp     = {r_held[0][2:0], r_held[1][5:0], r_held[2][5:0], b[5:0]};
                min_cp = utfv_pkg::MIN_CP_4;
            end
        endcase
    end

    always_comb begin
        job          = '0;
        job.status   = utfv_pkg::ST_OK;
        job.last_idx = 2'd0;
        job.rel      = 1'b0;
        n_count      = r_count;
        n_poison     = r_poison;
        held_wr      = 1'b0;
        if (r_poison) begin
            job.status = utfv_pkg::ST_POISONED;
        end else if (i_item.command == utfv_pkg::CMD_FINISH) begin
            if (r_count != 2'd0) begin
                job.status = utfv_pkg::ST_INCOMPLETE;
                n_poison   = 1'b1;
                n_count    = 2'd0;
            end
        end else if (r_count == 2'd0) begin
            if (len_b == 3'd0) begin
                job.status = utfv_pkg::ST_BAD_LEAD;
                n_poison   = 1'b1;
            end else if (len_b == 3'd1) begin
                job.rel    = 1'b1;
                job.seq[0] = b;
            end else begin
                held_wr = 1'b1;
                n_count = 2'd1;
            end
        end else if (b[7:6] != 2'b10) begin
            job.status = utfv_pkg::ST_BAD_CONT;
            n_poison   = 1'b1;
            n_count    = 2'd0;
        end else if (({1'b0, r_count} + 3'd1) < len_h) begin
            held_wr = 1'b1;
            n_count = r_count + 2'd1;
        end else begin
            // sequence complete: range checks on the assembled code point
            n_count = 2'd0;
            if (cp < min_cp) begin
                job.status = utfv_pkg::ST_OVERLONG;
                n_poison   = 1'b1;
            end else if (cp >= utfv_pkg::SURR_LO && cp <= utfv_pkg::SURR_HI) begin
                job.status = utfv_pkg::ST_SURROGATE;
                n_poison   = 1'b1;
            end else if (cp > utfv_pkg::MAX_CP) begin
                job.status = utfv_pkg::ST_TOO_LARGE;
                n_poison   = 1'b1;
            end else begin
                job.rel      = 1'b1;
                job.last_idx = r_count;
                job.seq[0]   = r_held[0];
                job.seq[1]   = (len_h == 3'd2) ? b : r_held[1];
                job.seq[2]   = (len_h == 3'd3) ? b : r_held[2];
                job.seq[3]   = b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 2'd0;
            r_poison <= 1'b0;
        end else if (i_accept) begin
            r_count  <= n_count;
            r_poison <= n_poison;
        end
    end

    // held bytes carry no reset; only entries below the count are read
    always_ff @(posedge i_clk) begin
        if (i_accept && held_wr) begin
            r_held[r_count] <= b;
        end
    end

    assign o_push.valid = i_accept;
    assign o_push.job   = job;

endmodule

FILE: rtl/utfv_queue.sv
// utfv_queue: short FIFO of classified jobs between front and back.
// Depends on utfv_pkg. DEPTH must be a power of two, at least 2.
module utfv_queue #(
    parameter int unsigned DEPTH = utfv_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  utfv_pkg::t_job_push i_push,
    input  logic                i_pop,
    output utfv_pkg::t_job      o_head,
    output logic                o_full,
    output logic                o_empty
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    utfv_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;

    logic do_wr;
    logic do_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_wr   = i_push.valid && !o_full;
    assign do_rd   = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) r_wr_ptr <= r_wr_ptr + PW'(1);
            if (do_rd) r_rd_ptr <= r_rd_ptr + PW'(1);
            case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

endmodule

FILE: rtl/utfv_back.sv
// utfv_back: takes jobs from the queue and emits their results one per cycle while pop is high.
// Depends on utfv_pkg.
module utfv_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  utfv_pkg::t_job      i_head,
    input  logic                i_q_empty,
    output logic                o_q_pop,
    output utfv_pkg::t_out_item o_result,
    output logic                o_empty,
    input  logic                i_pop
);

    utfv_pkg::t_job r_job;
    logic [1:0]     r_idx;
    logic           r_busy;

    logic at_last;
    logic done;
    logic load;

    assign at_last = (r_idx == r_job.last_idx);
    assign done    = r_busy && i_pop && at_last;
    assign load    = !i_q_empty && (!r_busy || done);
    assign o_q_pop = load;
    assign o_empty = !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (done) begin
            r_busy <= 1'b0;
        end else if (r_busy && i_pop) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_head;
        end
    end

    assign o_result.out_byte   = r_job.rel ? r_job.seq[r_idx] : 8'd0;
    assign o_result.byte_valid = r_job.rel;
    assign o_result.status     = r_job.status;
    assign o_result.last       = at_last;

endmodule

FILE: rtl/utf8_stream_validator.sv
// utf8_stream_validator: top level of the streaming UTF-8 validator.
// Depends on utfv_pkg, utfv_front, utfv_queue and utfv_back.
//
// Usage notes
//   Input channel: queue-style. An item (command, byte_value) is taken at a
//   rising edge with push high and full low. command feed passes one byte,
//   command finish closes the stream.
//   Result channel: queue-style. While empty is low the oldest result sits on
//   o_result; it is taken at an edge with pop high. Every item gives at least
//   one result; a completed valid sequence gives one result per byte, last
//   marks the final result of an item.
//   Path: an accepted item's job is written into the job queue, then loaded
//   into the result register, where its first result is shown.
//   Throughput: one item per cycle while results are drained. Each job gives
//   one result per pop (1 to 4), so the output port sets the rate; each held
//   byte of a longer sequence also gives a status-only result.
//   Stalls: the job queue (QUEUE_DEPTH entries) plus the result register let
//   the front keep accepting while pop is held low; full rises once the
//   queue is full and a stalled result holds steady.
//   Reset: synchronous, active low; clears pending count, poison flag, queue
//   and output state. No clearing pass; the block is ready the cycle after.
//   Errors poison the block until the next reset.
module utf8_stream_validator #(
    parameter int unsigned QUEUE_DEPTH = utfv_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  utfv_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output utfv_pkg::t_out_item o_result
);

    utfv_pkg::t_job_push front_push;
    utfv_pkg::t_job      q_head;
    logic                q_empty;
    logic                q_pop;
    logic                accept;

    assign accept = push && !full;

    // front: classify and update the pending-sequence state
    utfv_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_push   (front_push)
    );

    // decoupling queue; its full flag is the input back-pressure
    utfv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (full),
        .o_empty (q_empty)
    );

    // back: expand each job into its results
    utfv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (q_head),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_result  (o_result),
        .o_empty   (empty),
        .i_pop     (pop)
    );

endmodule

FILE: rtl/utfv_checker.sv
// utfv_checker: port-level assertions for utf8_stream_validator, bound to the top.
// Depends on utfv_pkg.
module utfv_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input utfv_pkg::t_out_item o_result
);

    // reset leaves no result pending and room for input
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("results or full flag left after reset");

    // a stalled result must not change
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("stalled result changed");

    // released bytes always carry an ok status
    a_byte_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.byte_valid) |-> (o_result.status == utfv_pkg::ST_OK))
        else $error("released byte with error status");

    // a result without a byte is the only result of its item
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.byte_valid) |-> (o_result.last && o_result.out_byte == 8'd0))
        else $error("status-only result not marked last");

endmodule

bind utf8_stream_validator utfv_checker u_utfv_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

FILE: tb/utf8_stream_validator_test.sv
`timescale 1ns / 1ps
// Self-checking bench for utf8_stream_validator: a queue-fed driver, a popping monitor
// and a local UTF-8 predictor. Depends on utfv_pkg and the RTL top level only.
module utf8_stream_validator_test;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 8;       // margin after the last result is checked
    localparam int CYCLE_LIMIT   = 400000;  // guard against a hung run
    localparam int RANDOM_ITEMS  = 405;     // least number of items before the closing error
    localparam int NOISE_ITEMS   = 20;      // items sent once the block is poisoned

    // One pending item; wait_drain holds it back until every due result is in.
    typedef struct {
        utfv_pkg::t_in_item item;
        bit                 wait_drain;
    } t_feed;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                push    = 1'b0;
    logic                pop     = 1'b0;
    utfv_pkg::t_in_item  in_item = '0;
    logic                full;
    logic                empty;
    utfv_pkg::t_out_item result;

    utf8_stream_validator uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (in_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (result)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    t_feed               feed_q[$];     // items still to be sent
    utfv_pkg::t_out_item due_q[$];      // results predicted but not yet popped

    // Predictor state: the pending sequence and the sticky poison flag.
    logic [7:0]  held_seq[3];
    int unsigned held_n   = 0;
    bit          poisoned = 1'b0;

    int unsigned       fail_cnt    = 0;
    int unsigned       sent_cnt    = 0;
    int unsigned       result_cnt  = 0;
    int unsigned       release_cnt = 0;
    int unsigned       cycle_cnt   = 0;
    bit                pause_next  = 1'b0;
    utfv_pkg::t_status err_kind    = utfv_pkg::ST_OK;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Length a lead byte asks for; 0 marks a byte that cannot start a sequence.
    function automatic int unsigned lead_len(logic [7:0] b);
        if (b[7] == 1'b0)          return 1;
        if (b[7:5] == 3'b110)      return 2;
        if (b[7:4] == 4'b1110)     return 3;
        if (b[7:3] == 5'b11110)    return 4;
        return 0;
    endfunction

    task automatic note_result(logic [7:0] b, logic v, utfv_pkg::t_status s, logic l);
        utfv_pkg::t_out_item r;
        r.out_byte   = b;
        r.byte_valid = v;
        r.status     = s;
        r.last       = l;
        due_q = {due_q, r};
    endtask

    // Any error drops the held bytes and poisons the block until reset.
    task automatic poison(utfv_pkg::t_status s);
        poisoned = 1'b1;
        held_n   = 0;
        note_result(8'h00, 1'b0, s, 1'b1);
    endtask

    task automatic predict_utf8(utfv_pkg::t_in_item it);
        logic [7:0]  seq[4];
        int unsigned len;
        int unsigned cp;
        int unsigned min_cp;
        if (poisoned) begin
            note_result(8'h00, 1'b0, utfv_pkg::ST_POISONED, 1'b1);
        end else if (it.command == utfv_pkg::CMD_FINISH) begin
            if (held_n != 0) begin
                poison(utfv_pkg::ST_INCOMPLETE);
            end else begin
                note_result(8'h00, 1'b0, utfv_pkg::ST_OK, 1'b1);
            end
        end else if (held_n == 0) begin
            len = lead_len(it.byte_value);
            if (len == 0) begin
                poison(utfv_pkg::ST_BAD_LEAD);
            end else if (len == 1) begin
                note_result(it.byte_value, 1'b1, utfv_pkg::ST_OK, 1'b1);
            end else begin
                held_seq[0] = it.byte_value;
                held_n      = 1;
                note_result(8'h00, 1'b0, utfv_pkg::ST_OK, 1'b1);
            end
        end else if (it.byte_value[7:6] != 2'b10) begin
            // a non-continuation byte is rejected at once, sequence complete or not
            poison(utfv_pkg::ST_BAD_CONT);
        end else begin
            len = lead_len(held_seq[0]);
            if (held_n + 1 < len) begin
                held_seq[held_n] = it.byte_value;
                held_n++;
                note_result(8'h00, 1'b0, utfv_pkg::ST_OK, 1'b1);
            end else begin
                for (int k = 0; k < held_n; k++) seq[k] = held_seq[k];
                seq[held_n] = it.byte_value;
                case (len)
                    2: begin
                        cp     = 32'(seq[0][4:0]);
                        min_cp = 32'(utfv_pkg::MIN_CP_2);
                    end
                    3: begin
                        cp     = 32'(seq[0][3:0]);
                        min_cp = 32'(utfv_pkg::MIN_CP_3);
                    end
                    default: begin
                        cp     = 32'(seq[0][2:0]);
                        min_cp = 32'(utfv_pkg::MIN_CP_4);
                    end
                endcase
                for (int k = 1; k < len; k++) cp = (cp << 6) | 32'(seq[k][5:0]);
                // range checks only once the whole sequence is in
                if (cp < min_cp) begin
                    poison(utfv_pkg::ST_OVERLONG);
                end else if (cp >= utfv_pkg::SURR_LO && cp <= utfv_pkg::SURR_HI) begin
                    poison(utfv_pkg::ST_SURROGATE);
                end else if (cp > utfv_pkg::MAX_CP) begin
                    poison(utfv_pkg::ST_TOO_LARGE);
                end else begin
                    held_n = 0;
                    for (int k = 0; k < len; k++)
                        note_result(seq[k], 1'b1, utfv_pkg::ST_OK, k == len - 1);
                end
            end
        end
    endtask

    task automatic check_result(utfv_pkg::t_out_item got);
        utfv_pkg::t_out_item want;
        result_cnt++;
        if (due_q.size() == 0) begin
            $error("unexpected result: out_byte %h byte_valid %b status %0d last %b",
                   got.out_byte, got.byte_valid, got.status, got.last);
            fail_cnt++;
        end else begin
            want = due_q.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
                fail_cnt++;
            end
            if (got.byte_valid !== want.byte_valid) begin
                $error("byte_valid: expected %b, got %b", want.byte_valid, got.byte_valid);
                fail_cnt++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                fail_cnt++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %b, got %b", want.last, got.last);
                fail_cnt++;
            end
            if (want.byte_valid) release_cnt++;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic add_feed(logic [7:0] b);
        t_feed f;
        f.item.command    = utfv_pkg::CMD_FEED;
        f.item.byte_value = b;
        f.wait_drain      = pause_next;
        pause_next        = 1'b0;
        feed_q = {feed_q, f};
    endtask

    // byte_value is don't-care on a finish, so it is randomised too
    task automatic add_finish();
        t_feed f;
        f.item.command    = utfv_pkg::CMD_FINISH;
        f.item.byte_value = 8'($urandom);
        f.wait_drain      = pause_next;
        pause_next        = 1'b0;
        feed_q = {feed_q, f};
    endtask

    // Legal code point for an encoding length, leaning now and then on the range ends.
    function automatic logic [20:0] rand_cp(int unsigned len);
        logic [20:0] lo;
        logic [20:0] hi;
        logic [20:0] cp;
        int unsigned pick;
        case (len)
            1:       begin lo = 21'h0;      hi = 21'h7F;     end
            2:       begin lo = 21'h80;     hi = 21'h7FF;    end
            3:       begin lo = 21'h800;    hi = 21'hFFFF;   end
            default: begin lo = 21'h10000;  hi = 21'h10FFFF; end
        endcase
        pick = $urandom_range(0, 7);
        if (pick == 0) return lo;
        if (pick == 1) return hi;
        do cp = 21'($urandom_range(lo, hi));
        while (cp >= utfv_pkg::SURR_LO && cp <= utfv_pkg::SURR_HI);
        return cp;
    endfunction

    // Encode cp in len bytes (overlong forms included) and send the first n.
    task automatic add_seq(logic [20:0] cp, int unsigned len, int unsigned n);
        logic [7:0] enc[4];
        case (len)
            1: enc[0] = {1'b0, cp[6:0]};
            2: begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3: begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default: begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int k = 0; k < n; k++) add_feed(enc[k]);
    endtask

    // ------------------------------------------------------------------
    // Driver: presents the head of feed_q, predicts on acceptance
    // ------------------------------------------------------------------
    int unsigned send_gap    = 0;
    bit          send_steady = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push     <= 1'b0;
            send_gap = 0;
        end else begin
            if (push && !full) begin
                predict_utf8(in_item);
                sent_cnt++;
                void'(feed_q.pop_front());
                // occasionally flip between back-to-back and gappy sending
                if ($urandom_range(0, 29) == 0) send_steady = !send_steady;
                send_gap = send_steady ? 0 : $urandom_range(0, 9);
            end
            if (send_gap != 0) begin
                send_gap--;
                push <= 1'b0;
            end else if (feed_q.size() != 0 &&
                         !(feed_q[0].wait_drain && due_q.size() != 0)) begin
                push    <= 1'b1;
                in_item <= feed_q[0].item;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: pops results with random stalls and checks each one
    // ------------------------------------------------------------------
    int unsigned take_gap    = 0;
    bit          take_steady = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop      <= 1'b0;
            take_gap = 0;
        end else begin
            if (pop && !empty) begin
                check_result(result);
                if ($urandom_range(0, 29) == 0) take_steady = !take_steady;
                take_gap = take_steady ? 0 : $urandom_range(0, 9);
            end
            if (take_gap != 0) begin
                take_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stream content and end of run
    // ------------------------------------------------------------------
    // Poison is sticky and reset comes only once, so the stream stays legal
    // until its tail, where one randomly chosen error closes it.
    initial begin : stimulus
        int unsigned len;
        logic [7:0]  b;
        bit          paused;
        paused = 1'b0;

        // range ends of lengths 1, 2 and 4, the low end of length 3, either side
        // of the surrogate gap, and a finish with nothing held
        add_seq(21'h0, 1, 1);
        add_seq(21'h7F, 1, 1);
        add_seq(21'h80, 2, 2);
        add_seq(21'h7FF, 2, 2);
        add_seq(21'h800, 3, 3);
        add_seq(21'hD7FF, 3, 3);
        add_seq(21'hE000, 3, 3);
        add_seq(21'h10000, 4, 4);
        add_seq(21'h10FFFF, 4, 4);
        add_finish();

        // random legal text with the odd finish between characters
        while (feed_q.size() < RANDOM_ITEMS) begin
            if (!paused && feed_q.size() >= RANDOM_ITEMS / 2) begin
                pause_next = 1'b1;   // hold the sender until the block drains
                paused     = 1'b1;
            end
            if ($urandom_range(0, 15) == 0) begin
                add_finish();
            end else begin
                len = $urandom_range(1, 4);
                add_seq(rand_cp(len), len, len);
            end
        end

        // closing error
        err_kind = utfv_pkg::t_status'($urandom_range(utfv_pkg::ST_BAD_LEAD,
                                                      utfv_pkg::ST_INCOMPLETE));
        case (err_kind)
            utfv_pkg::ST_BAD_LEAD: begin
                if ($urandom_range(0, 1) == 0) add_feed(8'($urandom_range(8'h80, 8'hBF)));
                else                           add_feed(8'($urandom_range(8'hF8, 8'hFF)));
            end
            utfv_pkg::ST_BAD_CONT: begin
                len = $urandom_range(2, 4);
                add_seq(rand_cp(len), len, $urandom_range(1, len - 1));
                do b = 8'($urandom); while (b[7:6] == 2'b10);
                add_feed(b);
            end
            utfv_pkg::ST_OVERLONG: begin
                len = $urandom_range(2, 4);
                case (len)
                    2: add_seq(21'($urandom_range(0, utfv_pkg::MIN_CP_2 - 1)), len, len);
                    3: add_seq(21'($urandom_range(0, utfv_pkg::MIN_CP_3 - 1)), len, len);
                    default:
                       add_seq(21'($urandom_range(0, utfv_pkg::MIN_CP_4 - 1)), len, len);
                endcase
            end
            utfv_pkg::ST_SURROGATE:
                add_seq(21'($urandom_range(utfv_pkg::SURR_LO, utfv_pkg::SURR_HI)), 3, 3);
            utfv_pkg::ST_TOO_LARGE:
                add_seq(21'($urandom_range(utfv_pkg::MAX_CP + 1, 21'h1FFFFF)), 4, 4);
            default: begin
                // incomplete: a cut-off sequence, then finish
                len = $urandom_range(2, 4);
                add_seq(rand_cp(len), len, $urandom_range(1, len - 1));
                add_finish();
            end
        endcase

        // anything after the error must come back poisoned
        repeat (NOISE_ITEMS) begin
            if ($urandom_range(0, 4) == 0) add_finish();
            else                           add_feed(8'($urandom));
        end

        while (feed_q.size() != 0 || due_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d items, checked %0d results of which %0d released bytes.",
                 sent_cnt, result_cnt, release_cnt);
        $display("Stream was legal text ended by a %s error and %0d poisoned items.",
                 err_kind.name(), NOISE_ITEMS);
        if (fail_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
